FILE: rtl/core/g2j_pkg.sv
// ----------------------------------------------------------------------------
// Gregorian to Jalali date conversion - shared types and constants
// Payload structs, calendar constants and fixed-point reciprocals that
// replace the divisions by constants in the datapath.
// ----------------------------------------------------------------------------
package g2j_pkg;

    // Input transfer: one Gregorian date
    typedef struct packed {
        logic [15:0] greg_year;
        logic [3:0]  greg_month;
        logic [4:0]  greg_day;
    } t_greg_date;

    // Output transfer: one Jalali date
    typedef struct packed {
        logic [15:0] jal_year;
        logic [3:0]  jal_month;
        logic [4:0]  jal_day;
    } t_jal_date;

    // Calendar constants
    localparam int unsigned DAY_BASE        = 355666;
    localparam int unsigned CYC33_DAYS      = 12053;
    localparam int unsigned CYC4_DAYS       = 1461;
    localparam int unsigned YEAR_DAYS       = 365;
    localparam int unsigned FIRST_HALF_DAYS = 186;
    localparam int unsigned CYC33_YEARS     = 33;
    localparam int          YEAR_BASE       = -1595;

    // Day count width: the largest count stays below 2**25
    localparam int CNT_W = 25;

    // Reciprocals, rounded up, exact for the operand ranges used here
    // floor(x/100) = (x * DIV100_MUL) >> DIV100_SH for x < 91000
    localparam int          DIV100_SH  = 23;
    localparam logic [16:0] DIV100_MUL = 17'(((64'd1 << DIV100_SH) + 64'd99) / 64'd100);
    // floor(x/12053) for x < 2**25
    localparam int          DIV33_SH   = 39;
    localparam logic [25:0] DIV33_MUL  =
        26'(((64'd1 << DIV33_SH) + 64'(CYC33_DAYS) - 64'd1) / 64'(CYC33_DAYS));
    // floor(x/1461) for x < 2**14
    localparam int          DIV4_SH    = 25;
    localparam logic [14:0] DIV4_MUL   =
        15'(((64'd1 << DIV4_SH) + 64'(CYC4_DAYS) - 64'd1) / 64'(CYC4_DAYS));

    // Days before the first of each Gregorian month; bad months read as January
    function automatic logic [8:0] month_offset(input logic [3:0] month);
        logic [8:0] offs;
        case (month)
            4'd1:    offs = 9'd0;
            4'd2:    offs = 9'd31;
            4'd3:    offs = 9'd59;
            4'd4:    offs = 9'd90;
            4'd5:    offs = 9'd120;
            4'd6:    offs = 9'd151;
            4'd7:    offs = 9'd181;
            4'd8:    offs = 9'd212;
            4'd9:    offs = 9'd243;
            4'd10:   offs = 9'd273;
            4'd11:   offs = 9'd304;
            4'd12:   offs = 9'd334;
            default: offs = 9'd0;
        endcase
        return offs;
    endfunction

endpackage

FILE: rtl/core/gregorian_to_jalali_date_core.sv
// ----------------------------------------------------------------------------
// Gregorian to Jalali date converter core
// Eight-stage pipeline: day count, 33-year cycle, 4-year cycle, single year,
// then month and day of the Jalali date.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  : i_in_valid / o_in_ready carry i_date (Gregorian y/m/d).
//   Output channel : o_out_valid / i_out_ready carry o_date (Jalali y/m/d).
//   Every input transfer yields exactly one output transfer, in order.
//   Throughput: one date per cycle when the output is not stalled, set by
//   the register stages; the divides by 100, 12053 and 1461 are reciprocal
//   multiplies, the last two in stages of their own.
//   Stall: each stage holds while the stage after it is full and held, so a
//   stalled receiver freezes the full stages and empty stages still fill;
//   o_in_ready drops once the pipeline is full up to the first stage.
//   Reset (i_rst_n low, synchronous) clears all stage valid bits; the data
//   registers are not reset. The output year is the low 16 bits and wraps
//   for Gregorian years before 622.
// ----------------------------------------------------------------------------
module gregorian_to_jalali_date_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  g2j_pkg::t_greg_date i_date,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output g2j_pkg::t_jal_date  o_date
);
    import g2j_pkg::*;

    localparam int NSTG = 8;

    // Stage valid bits and per-stage advance enables
    logic [NSTG:1] r_vld;
    logic [NSTG:1] rdy;

    // Stage 1: products and small terms of the day count
    logic [CNT_W-1:0] r1_y365, n1_y365;
    logic [14:0]      r1_q4y,  n1_q4y;
    logic [33:0]      r1_p100, n1_p100;
    logic [31:0]      r1_p400, n1_p400;
    logic [8:0]       r1_dm,   n1_dm;
    logic [16:0]      leap_yr;
    logic [16:0]      ly_plus99;
    logic [14:0]      ly_div4_400;

    // Stage 2: absolute day count
    logic [CNT_W-1:0] r2_cnt, n2_cnt;

    // Stage 3: 33-year cycle reciprocal product
    logic [CNT_W+25:0] r3_p33, n3_p33;
    logic [CNT_W-1:0]  r3_cnt;

    // Stage 4: 33-year quotient applied
    logic [13:0] r4_r33, n4_r33;
    logic [15:0] r4_jy,  n4_jy;
    logic [11:0] q33;

    // Stage 5: 4-year cycle reciprocal product
    logic [28:0] r5_p4, n5_p4;
    logic [13:0] r5_r33;
    logic [15:0] r5_jy;

    // Stage 6: 4-year quotient applied
    logic [10:0] r6_r4, n6_r4;
    logic [15:0] r6_jy, n6_jy;
    logic [3:0]  q4;

    // Stage 7: day of year and final year
    logic [8:0]  r7_ry, n7_ry;
    logic [15:0] r7_jy, n7_jy;
    logic [10:0] r4_m1;
    logic [1:0]  qy;

    // Stage 8: output register
    t_jal_date r8_date, n8_date;
    logic [8:0] u_half;
    logic [2:0] q_mon;

    // ------------------------------------------------------------------
    // Flow control: a stage takes new data when empty or when it moves on
    always_comb begin
        rdy[NSTG] = !r_vld[NSTG] || i_out_ready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign o_in_ready  = rdy[1];
    assign o_out_valid = r_vld[NSTG];
    assign o_date      = r8_date;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[1]) begin
                r_vld[1] <= i_in_valid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: 365*y, leap terms via reciprocals, day plus month offset
    always_comb begin
        leap_yr     = (i_date.greg_month > 4'd2) ? (17'(i_date.greg_year) + 17'd1)
                                                 : 17'(i_date.greg_year);
        ly_plus99   = leap_yr + 17'd99;
        ly_div4_400 = 15'((18'(leap_yr) + 18'd399) >> 2);
        n1_y365     = CNT_W'(i_date.greg_year) * CNT_W'(YEAR_DAYS);
        n1_q4y      = 15'((18'(leap_yr) + 18'd3) >> 2);
        n1_p100     = 34'(ly_plus99) * 34'(DIV100_MUL);
        n1_p400     = 32'(ly_div4_400) * 32'(DIV100_MUL);
        n1_dm       = 9'(i_date.greg_day) + month_offset(i_date.greg_month);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r1_y365 <= n1_y365;
            r1_q4y  <= n1_q4y;
            r1_p100 <= n1_p100;
            r1_p400 <= n1_p400;
            r1_dm   <= n1_dm;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: sum the day count
    always_comb begin
        n2_cnt = CNT_W'(DAY_BASE) + r1_y365 + CNT_W'(r1_q4y)
               - CNT_W'(r1_p100[33:DIV100_SH]) + CNT_W'(r1_p400[31:DIV100_SH])
               + CNT_W'(r1_dm);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r2_cnt <= n2_cnt;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: count / 12053 as a reciprocal product
    assign n3_p33 = (CNT_W+26)'(r2_cnt) * (CNT_W+26)'(DIV33_MUL);

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r3_p33 <= n3_p33;
            r3_cnt <= r2_cnt;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: remainder in the 33-year cycle, year base plus 33 per cycle
    always_comb begin
        q33    = r3_p33[DIV33_SH+11:DIV33_SH];
        n4_r33 = 14'(r3_cnt - CNT_W'(q33) * CNT_W'(CYC33_DAYS));
        n4_jy  = 16'(YEAR_BASE) + 16'(32'(q33) * CYC33_YEARS);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            r4_r33 <= n4_r33;
            r4_jy  <= n4_jy;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: remainder / 1461 as a reciprocal product
    assign n5_p4 = 29'(r4_r33) * 29'(DIV4_MUL);

    always_ff @(posedge i_clk) begin
        if (rdy[5]) begin
            r5_p4  <= n5_p4;
            r5_r33 <= r4_r33;
            r5_jy  <= r4_jy;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: remainder in the 4-year cycle, four years per cycle
    always_comb begin
        q4    = r5_p4[DIV4_SH+3:DIV4_SH];
        n6_r4 = 11'(r5_r33 - 14'(q4) * 14'(CYC4_DAYS));
        n6_jy = r5_jy + {10'd0, q4, 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (rdy[6]) begin
            r6_r4 <= n6_r4;
            r6_jy <= n6_jy;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: single years; past day 365 drop one day and split by 365
    always_comb begin
        r4_m1 = r6_r4 - 11'd1;
        qy    = 2'd0;
        n7_ry = 9'(r6_r4);
        if (r6_r4 > 11'(YEAR_DAYS)) begin
            if (r4_m1 >= 11'(3 * YEAR_DAYS)) begin
                qy = 2'd3;
            end else if (r4_m1 >= 11'(2 * YEAR_DAYS)) begin
                qy = 2'd2;
            end else if (r4_m1 >= 11'(YEAR_DAYS)) begin
                qy = 2'd1;
            end
            n7_ry = 9'(r4_m1 - 11'(qy) * 11'(YEAR_DAYS));
        end
        n7_jy = r6_jy + 16'(qy);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[7]) begin
            r7_ry <= n7_ry;
            r7_jy <= n7_jy;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: six 31-day months, then 30-day months
    always_comb begin
        q_mon  = 3'd0;
        u_half = r7_ry - 9'(FIRST_HALF_DAYS);
        if (r7_ry < 9'(FIRST_HALF_DAYS)) begin
            for (int k = 1; k <= 5; k++) begin
                if (r7_ry >= 9'(k * 31)) begin
                    q_mon = q_mon + 3'd1;
                end
            end
            n8_date.jal_month = 4'd1 + 4'(q_mon);
            n8_date.jal_day   = 5'(r7_ry - 9'(q_mon) * 9'd31) + 5'd1;
        end else begin
            for (int k = 1; k <= 5; k++) begin
                if (u_half >= 9'(k * 30)) begin
                    q_mon = q_mon + 3'd1;
                end
            end
            n8_date.jal_month = 4'd7 + 4'(q_mon);
            n8_date.jal_day   = 5'(u_half - 9'(q_mon) * 9'd30) + 5'd1;
        end
        n8_date.jal_year = r7_jy;
    end

    always_ff @(posedge i_clk) begin
        if (rdy[8]) begin
            r8_date <= n8_date;
        end
    end

    // ------------------------------------------------------------------
    // Checks on the reciprocal divides and the month split
`ifndef SYNTHESIS
    a_rem33_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] |-> (r4_r33 < 14'(CYC33_DAYS)))
        else $error("33-year cycle remainder out of range");

    a_rem4_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[6] |-> (r6_r4 < 11'(CYC4_DAYS)))
        else $error("4-year cycle remainder out of range");

    a_day_of_year: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[7] |-> (r7_ry <= 9'(YEAR_DAYS)))
        else $error("day of year out of range");

    a_out_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_date.jal_month >= 4'd1 && o_date.jal_month <= 4'd12
                         && o_date.jal_day >= 5'd1))
        else $error("output month or day out of range");
`endif

endmodule
